// File: rtl/itrd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itrd_pkg: shared definitions for the radix digit converter
// Field widths, radix limits, ASCII constants, divider control and helpers.
// ----------------------------------------------------------------------------
package itrd_pkg;

    localparam int VALUE_IN_BITS      = 32;
    localparam int POS_BITS           = 31;
    localparam int VALUE_BITS_DEFAULT = 31;

    localparam int RADIX_BITS     = 6;
    localparam int DIGIT_BITS     = 6;
    localparam int CHAR_BITS      = 7;
    localparam int STORE_DEPTH    = 31;
    localparam int COUNT_BITS     = $clog2(STORE_DEPTH);
    localparam int RADIX_MIN      = 2;
    localparam int RADIX_MAX      = 36;
    localparam int RADIX_COUNT    = RADIX_MAX - RADIX_MIN + 1;
    localparam int RADIX_IDX_BITS = $clog2(RADIX_COUNT);

    localparam logic [RADIX_BITS-1:0] RADIX_RESET = 6'd10;
    localparam logic [CHAR_BITS-1:0]  CHAR_ZERO   = 7'h30;
    localparam logic [CHAR_BITS-1:0]  CHAR_A      = 7'h41;
    localparam logic [DIGIT_BITS-1:0] DIGIT_NINE  = 6'd9;
    localparam logic [DIGIT_BITS-1:0] DIGIT_TEN   = 6'd10;

    // divider control from the sequencer
    typedef struct packed {
        logic load;    // latch reciprocal for the current radix
        logic mul_en;  // multiply dividend by reciprocal
    } div_ctrl_t;

    // out-of-range radix is pinned to the nearest legal base
    function automatic logic [RADIX_BITS-1:0] clamp_radix(input logic [RADIX_BITS-1:0] r);
        logic [RADIX_BITS-1:0] c;
        if (r < RADIX_BITS'(RADIX_MIN))
        begin
            c = RADIX_BITS'(RADIX_MIN);
        end
        else if (r > RADIX_BITS'(RADIX_MAX))
        begin
            c = RADIX_BITS'(RADIX_MAX);
        end
        else
        begin
            c = r;
        end
        return c;
    endfunction

    function automatic logic [CHAR_BITS-1:0] digit_to_ascii(input logic [DIGIT_BITS-1:0] d);
        logic [CHAR_BITS-1:0] c;
        if (d <= DIGIT_NINE)
        begin
            c = CHAR_ZERO + CHAR_BITS'(d);
        end
        else
        begin
            c = CHAR_A + CHAR_BITS'(d - DIGIT_TEN);
        end
        return c;
    endfunction

endpackage

// File: rtl/itrd_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itrd_ram: generic single-write, single-read memory
// One write port, one read port with registered read data and read enable.
// ----------------------------------------------------------------------------
module itrd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: rtl/itrd_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itrd_fifo: two-entry queue between front and back
// Decouples input acceptance from the digit sequencer.
// ----------------------------------------------------------------------------
module itrd_fifo #(
    parameter int WIDTH = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    logic [WIDTH-1:0] slot_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: rtl/itrd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itrd_front: input classifier
// Flags non-positive values as empty and saturates to the work width.
// ----------------------------------------------------------------------------
module itrd_front #(
    parameter int WORK_BITS = 31
) (
    input  logic [itrd_pkg::VALUE_IN_BITS-1:0] value,
    output logic [WORK_BITS:0]                 entry
);

    import itrd_pkg::*;

    logic                 is_empty;
    logic [WORK_BITS-1:0] work;

    // zero or sign bit set gives an empty conversion
    assign is_empty = (value == '0) || value[VALUE_IN_BITS-1];

    if (WORK_BITS < POS_BITS)
    begin : g_sat
        logic too_big;
        assign too_big = |value[POS_BITS-1:WORK_BITS];
        assign work    = too_big ? '1 : value[WORK_BITS-1:0];
    end
    else
    begin : g_pass
        assign work = value[WORK_BITS-1:0];
    end

    assign entry = {is_empty, work};

endmodule

// File: rtl/itrd_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itrd_div: divide by radix through an exact reciprocal
// Quotient = (n * m) >> (W + l) with m = ceil(2^(W+l) / d), l = ceil(log2 d).
// ----------------------------------------------------------------------------
module itrd_div #(
    parameter int WORK_BITS = 31
) (
    input  logic                            clk,
    input  itrd_pkg::div_ctrl_t             ctrl,
    input  logic [itrd_pkg::RADIX_BITS-1:0] radix,
    input  logic [WORK_BITS-1:0]            dividend,
    output logic [WORK_BITS-1:0]            quot,
    output logic [itrd_pkg::DIGIT_BITS-1:0] rem
);

    import itrd_pkg::*;

    localparam int MUL_BITS   = WORK_BITS + 1;
    localparam int PROD_BITS  = WORK_BITS + MUL_BITS;
    localparam int SHIFT_BITS = $clog2(WORK_BITS + RADIX_BITS + 1);

    logic [MUL_BITS-1:0]       recip_tab [RADIX_COUNT];
    logic [SHIFT_BITS-1:0]     shift_tab [RADIX_COUNT];
    logic [RADIX_IDX_BITS-1:0] tab_idx;
    logic [MUL_BITS-1:0]       recip_reg;
    logic [SHIFT_BITS-1:0]     shift_reg;
    logic [RADIX_BITS-1:0]     divisor_reg;
    logic [PROD_BITS-1:0]      prod_reg;
    logic [PROD_BITS-1:0]      prod_next;
    logic [PROD_BITS-1:0]      shifted;
    logic [DIGIT_BITS-1:0]     low_prod;

    for (genvar g = 0; g < RADIX_COUNT; g++)
    begin : g_recip
        localparam int          DIV   = RADIX_MIN + g;
        localparam int          LOG   = $clog2(DIV);
        localparam logic [63:0] NUM   = 64'd1 << (WORK_BITS + LOG);
        localparam logic [63:0] RECIP = (NUM + 64'(DIV) - 64'd1) / 64'(DIV);
        assign recip_tab[g] = RECIP[MUL_BITS-1:0];
        assign shift_tab[g] = SHIFT_BITS'(WORK_BITS + LOG);
    end

    assign tab_idx   = RADIX_IDX_BITS'(radix - RADIX_BITS'(RADIX_MIN));
    assign prod_next = PROD_BITS'(dividend) * PROD_BITS'(recip_reg);

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            recip_reg   <= recip_tab[tab_idx];
            shift_reg   <= shift_tab[tab_idx];
            divisor_reg <= radix;
        end
        if (ctrl.mul_en)
        begin
            prod_reg <= prod_next;
        end
    end

    assign shifted = prod_reg >> shift_reg;
    assign quot    = shifted[WORK_BITS-1:0];
    // remainder is below the radix, so six low bits suffice
    assign low_prod = quot[DIGIT_BITS-1:0] * divisor_reg;
    assign rem      = dividend[DIGIT_BITS-1:0] - low_prod;

endmodule

// File: rtl/itrd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itrd_back: digit sequencer
// Divides repeatedly, stacks remainders, then emits characters msd first.
// ----------------------------------------------------------------------------
module itrd_back #(
    parameter int WORK_BITS = 31
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [itrd_pkg::RADIX_BITS-1:0] radix,
    input  logic                            q_valid,
    output logic                            q_ready,
    input  logic [WORK_BITS:0]              q_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [itrd_pkg::CHAR_BITS-1:0]  out_char,
    output logic                            out_last,
    output logic                            out_empty
);

    import itrd_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_REM  = 3'd2;
    localparam logic [2:0] S_RD   = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0]            state_reg;
    logic [2:0]            state_next;
    logic [WORK_BITS-1:0]  w_reg;
    logic [WORK_BITS-1:0]  w_next;
    logic [COUNT_BITS-1:0] digit_count_reg;
    logic [COUNT_BITS-1:0] digit_count_next;
    logic [COUNT_BITS-1:0] idx_reg;
    logic [COUNT_BITS-1:0] idx_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [CHAR_BITS-1:0]  out_char_reg;
    logic [CHAR_BITS-1:0]  out_char_next;
    logic                  out_last_reg;
    logic                  out_last_next;
    logic                  out_empty_reg;
    logic                  out_empty_next;

    div_ctrl_t             div_ctrl;
    logic [WORK_BITS-1:0]  quot;
    logic [DIGIT_BITS-1:0] rem;
    logic                  ram_we;
    logic                  ram_re;
    logic [COUNT_BITS-1:0] ram_raddr;
    logic [DIGIT_BITS-1:0] ram_rdata;
    logic                  slot_free;

    itrd_div #(
        .WORK_BITS(WORK_BITS)
    ) u_div (
        .clk      (clk),
        .ctrl     (div_ctrl),
        .radix    (radix),
        .dividend (w_reg),
        .quot     (quot),
        .rem      (rem)
    );

    itrd_ram #(
        .WIDTH(DIGIT_BITS),
        .DEPTH(STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (digit_count_reg),
        .wdata (rem),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next       = state_reg;
        w_next           = w_reg;
        digit_count_next = digit_count_reg;
        idx_next         = idx_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        out_char_next    = out_char_reg;
        out_last_next    = out_last_reg;
        out_empty_next   = out_empty_reg;
        q_ready          = 1'b0;
        div_ctrl         = '0;
        ram_we           = 1'b0;
        ram_re           = 1'b0;
        ram_raddr        = idx_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    if (q_data[WORK_BITS])
                    begin
                        if (slot_free)
                        begin
                            q_ready          = 1'b1;
                            out_valid_next   = 1'b1;
                            out_char_next    = '0;
                            out_last_next    = 1'b1;
                            out_empty_next   = 1'b1;
                            digit_count_next = '0;
                        end
                    end
                    else
                    begin
                        q_ready          = 1'b1;
                        div_ctrl.load    = 1'b1;
                        w_next           = q_data[WORK_BITS-1:0];
                        digit_count_next = '0;
                        state_next       = S_MUL;
                    end
                end
            end
            S_MUL:
            begin
                div_ctrl.mul_en = 1'b1;
                state_next      = S_REM;
            end
            S_REM:
            begin
                ram_we           = 1'b1;
                w_next           = quot;
                digit_count_next = digit_count_reg + 1'b1;
                if ((quot == '0) || (digit_count_reg == COUNT_BITS'(STORE_DEPTH - 1)))
                begin
                    idx_next   = digit_count_reg;
                    state_next = S_RD;
                end
                else
                begin
                    state_next = S_MUL;
                end
            end
            S_RD:
            begin
                ram_re     = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = digit_to_ascii(ram_rdata);
                    out_last_next  = (idx_reg == '0);
                    out_empty_next = 1'b0;
                    if (idx_reg == '0)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next  = idx_reg - 1'b1;
                        ram_re    = 1'b1;
                        ram_raddr = idx_reg - 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            w_reg           <= '0;
            digit_count_reg <= '0;
            idx_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            w_reg           <= w_next;
            digit_count_reg <= digit_count_next;
            idx_reg         <= idx_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_char_reg  <= out_char_next;
        out_last_reg  <= out_last_next;
        out_empty_reg <= out_empty_next;
    end

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign out_last  = out_last_reg;
    assign out_empty = out_empty_reg;

endmodule

// File: rtl/integer_to_radix_digits.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_radix_digits: signed integer to ASCII digits in radix 2..36
// Stream in one value, stream out its digit characters, msd first.
// ----------------------------------------------------------------------------
// Each accepted value is converted to ASCII digits ('0'-'9', 'A'-'Z') in the
// radix held in the configuration register (reset 10; 0 and 1 act as 2, above
// 36 acts as 36). Characters leave most significant first, the final one with
// tlast set. A zero or negative value gives a single transfer with data 0,
// tlast 1 and tuser 1. Positive values wider than VALUE_BITS saturate to the
// largest VALUE_BITS value. Each digit passes through the divide loop (a
// reciprocal multiply, then a quotient/remainder step); the digit store is
// then read and characters are emitted one per cycle while the sink is
// ready (up to 31 digits). A two-entry queue sits between input and
// sequencer, so up to two further input transfers are taken while a
// conversion runs and the output register holds a character the sink has
// not taken. Update the radix only while the block is idle.
// ----------------------------------------------------------------------------
module integer_to_radix_digits #(
    parameter int VALUE_BITS = itrd_pkg::VALUE_BITS_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // radix register write
    input  logic                               radix_wr_en,
    input  logic [itrd_pkg::RADIX_BITS-1:0]    radix_wr_data,
    // input stream; tdata: [31:0] value
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [itrd_pkg::VALUE_IN_BITS-1:0] s_tdata,
    // output stream; tdata: [6:0] digit_char, [7] zero pad
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [7:0]                         m_tdata,
    output logic                               m_tlast,
    // tuser: [0] empty_res
    output logic                               m_tuser
);

    import itrd_pkg::*;

    // a positive 32-bit value never needs more than 31 bits
    localparam int WORK_BITS = (VALUE_BITS < POS_BITS) ? VALUE_BITS : POS_BITS;

    localparam logic [CHAR_BITS-1:0] CHAR_NINE = CHAR_ZERO + CHAR_BITS'(DIGIT_NINE);
    localparam logic [CHAR_BITS-1:0] CHAR_Z    =
        CHAR_A + CHAR_BITS'(RADIX_MAX - 1 - int'(DIGIT_TEN));

    logic [RADIX_BITS-1:0] radix_reg;
    logic [RADIX_BITS-1:0] radix_eff;
    logic [WORK_BITS:0]    front_entry;
    logic                  q_valid;
    logic                  q_ready;
    logic [WORK_BITS:0]    q_data;
    logic [CHAR_BITS-1:0]  out_char;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg <= RADIX_RESET;
        end
        else if (radix_wr_en)
        begin
            radix_reg <= radix_wr_data;
        end
    end

    assign radix_eff = clamp_radix(radix_reg);

    // front: classify and saturate the incoming value
    itrd_front #(
        .WORK_BITS(WORK_BITS)
    ) u_front (
        .value (s_tdata),
        .entry (front_entry)
    );

    // queue between front and sequencer
    itrd_fifo #(
        .WIDTH(WORK_BITS + 1)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (s_tvalid),
        .push_ready (s_tready),
        .push_data  (front_entry),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   (q_data)
    );

    // back: divide loop, digit store and output register
    itrd_back #(
        .WORK_BITS(WORK_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .radix     (radix_eff),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_data    (q_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_char  (out_char),
        .out_last  (m_tlast),
        .out_empty (m_tuser)
    );

    assign m_tdata = {1'b0, out_char};

    // empty result carries no character and closes the run
    a_empty_form: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tlast && (m_tdata == 8'd0))
        else $error("empty result not formed as a closing zero character");

    // every digit character is a legal ascii digit or letter
    a_digit_char: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |->
            !m_tdata[7] &&
            (((m_tdata[6:0] >= CHAR_ZERO) && (m_tdata[6:0] <= CHAR_NINE)) ||
             ((m_tdata[6:0] >= CHAR_A) && (m_tdata[6:0] <= CHAR_Z))))
        else $error("digit character out of range");

    // within a run the next character is ready right after a transfer
    a_run_gapless: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid)
        else $error("gap inside a digit run");

endmodule
